// File: rtl/rcfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfs_pkg
// Shared widths, constants and codes of the radio-control failsafe conditioner.
// ----------------------------------------------------------------------------
package rcfs_pkg;

	localparam int RAW_BITS_DEF = 12;
	localparam int SCALE_W      = 20;
	localparam int HOLD_W       = 8;
	localparam int Q_W          = 16;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = SCALE_W;

	// Result transfer: four Q2.14 channels, control bit, armed bit, padded to bytes.
	localparam int OUT_USED_W    = 4 * Q_W + 2;
	localparam int OUT_W         = ((OUT_USED_W + 7) / 8) * 8;
	localparam int OUT_CTL_BIT   = 4 * Q_W;
	localparam int OUT_ARMED_BIT = 4 * Q_W + 1;

	localparam logic [SCALE_W-1:0] THR_SCALE_RST  = SCALE_W'(65536);
	localparam logic [SCALE_W-1:0] AXIS_SCALE_RST = SCALE_W'(65536);
	localparam logic [HOLD_W-1:0]  CTL_HOLD_RST   = HOLD_W'(3);

	localparam int DECAY_CUTOFF = 500;
	localparam logic [Q_W-1:0] Q_MAX      = 16'd32767;
	localparam logic [Q_W-1:0] DEADBAND_Q = 16'd164;
	localparam logic [Q_W-1:0] ARM_HIGH_Q = 16'd12288;
	localparam logic [Q_W-1:0] ARM_LOW_Q  = 16'd1638;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THR_SCALE  = 2'd0,
		CFG_AXIS_SCALE = 2'd1,
		CFG_CTL_HOLD   = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ARM_WAIT_HIGH = 3'b001,
		ARM_WAIT_LOW  = 3'b010,
		ARM_DONE      = 3'b100
	} arm_state_t;

endpackage

// File: rtl/rc_failsafe_conditioner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_failsafe_conditioner
// Receiver channel store with failsafe decay, Q2.14 scaling, control debounce
// and an arming tracker.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                   Contents
// s_axis    in         s_axis_tvalid/s_axis_tready frame or timeout tick
// m_axis    out        m_axis_tvalid/m_axis_tready scaled channels and status
// cfg       in         cfg_wen (no wait)           scale and hold registers
//
// A transfer is accepted every cycle unless both stages hold items and the
// result is stalled. The held-channel stage updates the held channels; the
// result register takes the four scale multipliers, the debounce counter and
// the arming tracker. A stalled result holds its register while one more item
// waits in the held-channel stage. Reset clears held channels and all control.
// ----------------------------------------------------------------------------
module rc_failsafe_conditioner #(
	parameter int RAW_BITS = rcfs_pkg::RAW_BITS_DEF,
	localparam int IN_W = ((5 * RAW_BITS + 1 + 7) / 8) * 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// tdata: control_raw, yaw_raw, pitch_raw, roll_raw, throttle_raw, link_active
	input  logic [IN_W-1:0]                     s_axis_tdata,
	// tuser: op
	input  logic                                s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// tdata: throttle_out, roll_out, pitch_out, yaw_out, control_out, armed
	output logic [rcfs_pkg::OUT_W-1:0]          m_axis_tdata,
	input  logic                                cfg_wen,
	input  logic [rcfs_pkg::CFG_IDX_W-1:0]      cfg_addr,
	input  logic [rcfs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import rcfs_pkg::*;

	localparam int R     = RAW_BITS;
	localparam int CMP_W = R + 10;
	localparam int PA_W  = R + SCALE_W + 1;

	function automatic logic [Q_W-1:0] sat_axis(input logic signed [PA_W-1:0] p);
		logic signed [R+4:0] sh;
		logic signed [31:0]  w;
		sh = p[PA_W-1:16];
		w  = 32'(sh);
		if (w > 32'sd32767)
			return 16'h7FFF;
		else if (w < -32'sd32768)
			return 16'h8000;
		else
			return w[Q_W-1:0];
	endfunction

	logic [SCALE_W-1:0] thr_scale_q;
	logic [SCALE_W-1:0] axis_scale_q;
	logic [HOLD_W-1:0]  ctl_hold_q;

	logic [R-1:0]        held_ctl_q;
	logic signed [R-1:0] held_yaw_q;
	logic signed [R-1:0] held_pitch_q;
	logic signed [R-1:0] held_roll_q;
	logic [R-1:0]        held_thr_q;
	logic [HOLD_W-1:0]   countdown_q;
	arm_state_t          arm_q;

	logic vld_s1;
	logic link_s1;
	logic vld_s2;
	logic [Q_W-1:0] thr_s2;
	logic [Q_W-1:0] roll_s2;
	logic [Q_W-1:0] pitch_s2;
	logic [Q_W-1:0] yaw_s2;
	logic           ctl_s2;
	logic           armed_s2;

	logic in_acc;
	logic adv_s1;

	logic [R-1:0]        in_ctl;
	logic signed [R-1:0] in_yaw;
	logic signed [R-1:0] in_pitch;
	logic signed [R-1:0] in_roll;
	logic [R-1:0]        in_thr;
	logic                in_link;

	logic signed [R-1:0] dec_yaw;
	logic signed [R-1:0] dec_pitch;
	logic signed [R-1:0] dec_roll;
	logic [R-1:0]        dec_thr;
	logic [R+6:0]        thr_x127;

	logic [R+SCALE_W-1:0] thr_prod;
	logic [31:0]          thr_wide;
	logic [Q_W-1:0]       thr_sat;
	logic [Q_W-1:0]       thr_fin;
	logic signed [PA_W-1:0] axis_k;
	logic signed [PA_W-1:0] roll_prod;
	logic signed [PA_W-1:0] pitch_prod;
	logic signed [PA_W-1:0] yaw_prod;

	logic              ctl_nx;
	logic [HOLD_W-1:0] countdown_nx;
	arm_state_t        arm_nx;

	function automatic logic signed [R-1:0] decay_axis(input logic signed [R-1:0] x);
		logic signed [R+2:0] ext;
		logic signed [R+2:0] x7;
		ext = (R+3)'(x);
		x7  = (ext <<< 3) - ext;
		return x7[R+2:3];
	endfunction

	assign in_ctl   = s_axis_tdata[R-1:0];
	assign in_yaw   = s_axis_tdata[2*R-1:R];
	assign in_pitch = s_axis_tdata[3*R-1:2*R];
	assign in_roll  = s_axis_tdata[4*R-1:3*R];
	assign in_thr   = s_axis_tdata[5*R-1:4*R];
	assign in_link  = s_axis_tdata[5*R];

	assign adv_s1        = vld_s1 && (!vld_s2 || m_axis_tready);
	assign s_axis_tready = !vld_s1 || adv_s1;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	assign dec_yaw   = decay_axis(held_yaw_q);
	assign dec_pitch = decay_axis(held_pitch_q);
	assign dec_roll  = decay_axis(held_roll_q);
	assign thr_x127  = {held_thr_q, 7'd0} - (R+7)'(held_thr_q);
	assign dec_thr   = thr_x127[R+6:7];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_scale_q  <= THR_SCALE_RST;
			axis_scale_q <= AXIS_SCALE_RST;
			ctl_hold_q   <= CTL_HOLD_RST;
		end else if (cfg_wen) begin
			case (cfg_addr)
				CFG_THR_SCALE:  thr_scale_q  <= cfg_wdata;
				CFG_AXIS_SCALE: axis_scale_q <= cfg_wdata;
				CFG_CTL_HOLD:   ctl_hold_q   <= cfg_wdata[HOLD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_ctl_q   <= '0;
			held_yaw_q   <= '0;
			held_pitch_q <= '0;
			held_roll_q  <= '0;
			held_thr_q   <= '0;
			vld_s1       <= 1'b0;
			link_s1      <= 1'b0;
		end else begin
			if (in_acc) begin
				link_s1 <= in_link;
				if (!s_axis_tuser) begin
					held_ctl_q   <= in_ctl;
					held_yaw_q   <= in_yaw;
					held_pitch_q <= in_pitch;
					held_roll_q  <= in_roll;
					held_thr_q   <= in_thr;
				end else begin
					held_yaw_q   <= dec_yaw;
					held_pitch_q <= dec_pitch;
					held_roll_q  <= dec_roll;
					held_thr_q   <= dec_thr;
					held_ctl_q   <= (CMP_W'(dec_thr) > CMP_W'(DECAY_CUTOFF)) ?
						R'(1) : '0;
				end
			end
			if (in_acc)
				vld_s1 <= 1'b1;
			else if (adv_s1)
				vld_s1 <= 1'b0;
		end
	end

	assign thr_prod = (R+SCALE_W)'(held_thr_q) * (R+SCALE_W)'(thr_scale_q);
	assign thr_wide = 32'(thr_prod[R+SCALE_W-1:16]);
	assign thr_sat  = (thr_wide > 32'(Q_MAX)) ? Q_MAX : thr_wide[Q_W-1:0];
	assign thr_fin  = (thr_sat < DEADBAND_Q) ? '0 : thr_sat;

	assign axis_k     = PA_W'($signed({1'b0, axis_scale_q}));
	assign roll_prod  = PA_W'(held_roll_q) * axis_k;
	assign pitch_prod = PA_W'(held_pitch_q) * axis_k;
	assign yaw_prod   = PA_W'(held_yaw_q) * axis_k;

	always_comb begin
		ctl_nx       = 1'b1;
		countdown_nx = countdown_q;
		if (held_ctl_q != '0)
			countdown_nx = ctl_hold_q;
		else if (countdown_q != '0)
			countdown_nx = countdown_q - HOLD_W'(1);
		else
			ctl_nx = 1'b0;
	end

	always_comb begin
		arm_nx = arm_q;
		case (arm_q)
			ARM_WAIT_HIGH: begin
				if (thr_fin >= ARM_HIGH_Q)
					arm_nx = ARM_WAIT_LOW;
			end
			ARM_WAIT_LOW: begin
				if (!link_s1)
					arm_nx = ARM_WAIT_HIGH;
				else if (thr_fin <= ARM_LOW_Q)
					arm_nx = ARM_DONE;
			end
			ARM_DONE: arm_nx = ARM_DONE;
			default: arm_nx = ARM_DONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			countdown_q <= '0;
			arm_q       <= ARM_WAIT_HIGH;
			vld_s2      <= 1'b0;
		end else begin
			if (adv_s1) begin
				countdown_q <= countdown_nx;
				arm_q       <= arm_nx;
				vld_s2      <= 1'b1;
			end else if (m_axis_tready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			thr_s2   <= thr_fin;
			roll_s2  <= sat_axis(roll_prod);
			pitch_s2 <= sat_axis(pitch_prod);
			yaw_s2   <= sat_axis(yaw_prod);
			ctl_s2   <= ctl_nx;
			armed_s2 <= (arm_nx == ARM_DONE);
		end
	end

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = {(OUT_W - OUT_USED_W)'(0), armed_s2, ctl_s2,
		yaw_s2, pitch_s2, roll_s2, thr_s2};

endmodule

// File: rtl/rcfs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfs_checker
// Port-level checks of the radio-control failsafe conditioner.
// ----------------------------------------------------------------------------
module rcfs_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_axis_tready,
	input logic                       m_axis_tvalid,
	input logic                       m_axis_tready,
	input logic [rcfs_pkg::OUT_W-1:0] m_axis_tdata
);
	import rcfs_pkg::*;

	logic           armed_seen_q;
	logic           out_xfer;
	logic [Q_W-1:0] thr;

	assign out_xfer = m_axis_tvalid && m_axis_tready;
	assign thr      = m_axis_tdata[Q_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			armed_seen_q <= 1'b0;
		else if (out_xfer && m_axis_tdata[OUT_ARMED_BIT])
			armed_seen_q <= 1'b1;
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_armed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		armed_seen_q && out_xfer |-> m_axis_tdata[OUT_ARMED_BIT])
		else $error("armed status dropped after arming");

	a_thr_deadband: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> thr == '0 || (thr >= DEADBAND_Q && !thr[Q_W-1]))
		else $error("throttle inside deadband or negative");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with no result pending");

endmodule

bind rc_failsafe_conditioner rcfs_checker u_rcfs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rc_failsafe_conditioner: a behavioral copy of the
// channel store, failsafe decay, scaling, control debounce and arming tracker
// predicts every result, and a checker compares each output transfer field
// by field. Directed frames and ticks lead, then random traffic under several
// register settings and handshake idling patterns, with directed tests between.
// ----------------------------------------------------------------------------
module testbench;
	import rcfs_pkg::*;

	localparam int RAW = RAW_BITS_DEF;
	localparam int IN_W = ((5 * RAW + 1 + 7) / 8) * 8;
	localparam int STALL_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct {
		bit                     op;
		logic [RAW-1:0]         control;
		logic signed [RAW-1:0]  yaw;
		logic signed [RAW-1:0]  pitch;
		logic signed [RAW-1:0]  roll;
		logic [RAW-1:0]         throttle;
		bit                     link;
	} rc_item_t;

	typedef struct {
		logic signed [Q_W-1:0] throttle;
		logic signed [Q_W-1:0] roll;
		logic signed [Q_W-1:0] pitch;
		logic signed [Q_W-1:0] yaw;
		bit                    control;
		bit                    armed;
	} rc_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_W-1:0]        s_axis_tdata;
	logic                   s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_W-1:0]       m_axis_tdata;
	logic                   cfg_wen;
	logic [CFG_IDX_W-1:0]   cfg_addr;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	// Behavioral copy of the block's registers and state.
	logic [SCALE_W-1:0]     thr_scale_cfg;
	logic [SCALE_W-1:0]     axis_scale_cfg;
	logic [HOLD_W-1:0]      hold_cfg;
	logic [RAW-1:0]         kept_control;
	logic signed [RAW-1:0]  kept_yaw;
	logic signed [RAW-1:0]  kept_pitch;
	logic signed [RAW-1:0]  kept_roll;
	logic [RAW-1:0]         kept_throttle;
	int                     zero_countdown;
	arm_state_t             arm_track;

	rc_result_t             predicted_results[$];
	int                     error_count;
	int                     items_sent;
	int                     src_idle_pct;
	int                     snk_idle_pct;
	bit                     stall_req;
	int                     stall_left;
	int                     quiet_cycles;

	rc_failsafe_conditioner dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wen       (cfg_wen),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic signed [Q_W-1:0] saturate_q(longint v);
		if (v > 32767)
			return 16'sd32767;
		if (v < -32768)
			return -16'sd32768;
		return Q_W'(v);
	endfunction

	function automatic logic signed [RAW-1:0] decay_axis(logic signed [RAW-1:0] v);
		longint p;
		p = longint'(v) * 7;
		return RAW'(p >>> 3);
	endfunction

	function automatic logic signed [Q_W-1:0] scale_axis_q(logic signed [RAW-1:0] v);
		longint p;
		p = longint'(v) * longint'(axis_scale_cfg);
		return saturate_q(p >>> 16);
	endfunction

	function automatic rc_result_t condition_channels(rc_item_t it);
		rc_result_t r;
		longint t;
		int thr_q;
		if (!it.op) begin
			kept_control = it.control;
			kept_yaw = it.yaw;
			kept_pitch = it.pitch;
			kept_roll = it.roll;
			kept_throttle = it.throttle;
		end else begin
			kept_roll = decay_axis(kept_roll);
			kept_pitch = decay_axis(kept_pitch);
			kept_yaw = decay_axis(kept_yaw);
			kept_throttle = RAW'((int'(kept_throttle) * 127) >> 7);
			kept_control = (int'(kept_throttle) > DECAY_CUTOFF) ? RAW'(1) : '0;
		end
		t = (longint'(kept_throttle) * longint'(thr_scale_cfg)) >> 16;
		thr_q = int'(saturate_q(t));
		if (thr_q < int'(DEADBAND_Q))
			thr_q = 0;
		r.throttle = Q_W'(thr_q);
		r.roll = scale_axis_q(kept_roll);
		r.pitch = scale_axis_q(kept_pitch);
		r.yaw = scale_axis_q(kept_yaw);
		r.control = 1'b1;
		if (kept_control != 0)
			zero_countdown = int'(hold_cfg);
		else if (zero_countdown > 0)
			zero_countdown--;
		else
			r.control = 1'b0;
		case (arm_track)
			ARM_WAIT_HIGH: begin
				if (thr_q >= int'(ARM_HIGH_Q))
					arm_track = ARM_WAIT_LOW;
			end
			ARM_WAIT_LOW: begin
				if (!it.link)
					arm_track = ARM_WAIT_HIGH;
				else if (thr_q <= int'(ARM_LOW_Q))
					arm_track = ARM_DONE;
			end
			default: ;
		endcase
		r.armed = (arm_track == ARM_DONE);
		return r;
	endfunction

	function automatic rc_item_t make_item(int op, int ctl, int yaw, int pitch, int roll,
			int thr, int link);
		rc_item_t it;
		it.op = 1'(op);
		it.control = RAW'(ctl);
		it.yaw = RAW'(yaw);
		it.pitch = RAW'(pitch);
		it.roll = RAW'(roll);
		it.throttle = RAW'(thr);
		it.link = 1'(link);
		return it;
	endfunction

	function automatic logic [RAW-1:0] pick_channel();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return RAW'(12'h800);
			3: return RAW'(12'h7FF);
			4: return RAW'($urandom_range(700));
			default: return RAW'($urandom);
		endcase
	endfunction

	function automatic rc_item_t random_item(bit op);
		rc_item_t it;
		it.op = op;
		case ($urandom_range(3))
			0, 1: it.control = '0;
			2: it.control = RAW'($urandom);
			default: it.control = RAW'(1);
		endcase
		it.yaw = pick_channel();
		it.pitch = pick_channel();
		it.roll = pick_channel();
		it.throttle = pick_channel();
		it.link = ($urandom_range(3) != 0);
		return it;
	endfunction

	task automatic send_item(input rc_item_t it);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= it.op;
		s_axis_tdata <= IN_W'({it.link, it.throttle, it.roll, it.pitch, it.yaw, it.control});
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predicted_results.push_back(condition_channels(it));
		items_sent++;
	endtask

	// The sender stops and waits until every predicted result has been checked.
	task automatic settle_outputs();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (predicted_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_regs(input logic [SCALE_W-1:0] thr_s,
			input logic [SCALE_W-1:0] axis_s, input logic [HOLD_W-1:0] hold);
		settle_outputs();
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_addr <= CFG_THR_SCALE;
		cfg_wdata <= thr_s;
		@(negedge clk);
		cfg_addr <= CFG_AXIS_SCALE;
		cfg_wdata <= axis_s;
		@(negedge clk);
		cfg_addr <= CFG_CTL_HOLD;
		cfg_wdata <= {12'($urandom), hold};
		@(negedge clk);
		cfg_addr <= CFG_UNUSED;
		cfg_wdata <= CFG_DATA_W'($urandom);
		@(negedge clk);
		cfg_wen <= 1'b0;
		thr_scale_cfg = thr_s;
		axis_scale_cfg = axis_s;
		hold_cfg = hold;
	endtask

	task automatic random_run(input int n);
		int stop_at;
		int len;
		int k;
		rc_item_t it;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			case ($urandom_range(9))
				0, 1, 2: send_item(random_item($urandom_range(3) == 0));
				3, 4: begin
					it = random_item(1'b0);
					it.throttle = RAW'($urandom_range(400, 4095));
					send_item(it);
					len = $urandom_range(1, 30);
					for (k = 0; k < len; k++)
						send_item(random_item(1'b1));
				end
				5, 6: begin
					it = random_item(1'b0);
					it.control = RAW'($urandom_range(1, 4095));
					send_item(it);
					len = $urandom_range(0, int'(hold_cfg) + 2);
					for (k = 0; k < len; k++) begin
						it = random_item(1'b0);
						it.control = '0;
						send_item(it);
					end
				end
				7, 8: begin
					it = random_item(1'b0);
					it.throttle = RAW'($urandom_range(3000, 4095));
					it.link = 1'b1;
					send_item(it);
					len = $urandom_range(0, 3);
					for (k = 0; k < len; k++)
						send_item(random_item($urandom_range(3) == 0));
					it = random_item(1'b0);
					it.throttle = RAW'($urandom_range(0, 400));
					it.link = ($urandom_range(4) != 0);
					send_item(it);
				end
				default: begin
					settle_outputs();
					send_item(random_item(1'($urandom_range(1))));
				end
			endcase
		end
	endtask

	task automatic test_reset_defaults();
		send_item(make_item(0, 0, 0, 0, 0, 0, 0));
		send_item(make_item(0, 4095, -2048, 2047, -2048, 4095, 1));
		send_item(make_item(1, 0, 2047, -1, 5, 12, 1));
		send_item(make_item(0, 0, -1, 1, 0, 163, 1));
		send_item(make_item(0, 0, -1, 1, 0, 164, 1));
		send_item(make_item(0, 0, 0, 0, 0, 0, 1));
		send_item(make_item(0, 0, 0, 0, 0, 0, 1));
		send_item(make_item(0, 0, 100, -100, 7, 505, 1));
		send_item(make_item(1, 4095, 0, 0, 0, 4095, 1));
		send_item(make_item(1, 4095, 0, 0, 0, 4095, 0));
	endtask

	task automatic test_scale_extremes();
		program_regs('1, '1, '0);
		send_item(make_item(0, 1, 2047, -2048, -1, 4095, 0));
		send_item(make_item(0, 0, 0, 0, 0, 0, 0));
		send_item(make_item(0, 0, 1, -1, 0, 4095, 1));
		send_item(make_item(0, 0, 1, -1, 0, 200, 1));
		program_regs('0, '0, '1);
		send_item(make_item(0, 4095, 2047, -2048, 2047, 4095, 0));
		send_item(make_item(1, 0, 0, 0, 0, 0, 1));
	endtask

	task automatic test_output_backpressure();
		int k;
		settle_outputs();
		@(posedge clk);
		stall_req = 1'b1;
		for (k = 0; k < 16; k++)
			send_item(random_item($urandom_range(3) == 0));
		settle_outputs();
	endtask

	task automatic test_arming_sequence();
		program_regs('1, SCALE_W'(65536), HOLD_W'(3));
		send_item(make_item(0, 1, 0, 0, 0, 4095, 1));
		send_item(make_item(0, 1, 0, 0, 0, 2000, 1));
		send_item(make_item(0, 1, 0, 0, 0, 100, 1));
		send_item(make_item(1, 0, 0, 0, 0, 0, 0));
	endtask

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			error_count++;
			if (error_count <= 10)
				$display("mismatch on %s: expected %0d, got %0d", name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		rc_result_t want;
		rc_result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.throttle = m_axis_tdata[15:0];
			got.roll = m_axis_tdata[31:16];
			got.pitch = m_axis_tdata[47:32];
			got.yaw = m_axis_tdata[63:48];
			got.control = m_axis_tdata[OUT_CTL_BIT];
			got.armed = m_axis_tdata[OUT_ARMED_BIT];
			if (predicted_results.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("unexpected result transfer: %h", m_axis_tdata);
			end else begin
				want = predicted_results.pop_front();
				check_field("throttle_out", want.throttle, got.throttle);
				check_field("roll_out", want.roll, got.roll);
				check_field("pitch_out", want.pitch, got.pitch);
				check_field("yaw_out", want.yaw, got.yaw);
				check_field("control_out", want.control, got.control);
				check_field("armed", want.armed, got.armed);
			end
		end
	end

	always @(negedge clk) begin
		if (stall_req) begin
			stall_left = STALL_CYCLES;
			stall_req = 1'b0;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wen)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;
		cfg_wen = 1'b0;
		cfg_addr = CFG_THR_SCALE;
		cfg_wdata = '0;
		thr_scale_cfg = THR_SCALE_RST;
		axis_scale_cfg = AXIS_SCALE_RST;
		hold_cfg = CTL_HOLD_RST;
		kept_control = '0;
		kept_yaw = '0;
		kept_pitch = '0;
		kept_roll = '0;
		kept_throttle = '0;
		zero_countdown = 0;
		arm_track = ARM_WAIT_HIGH;
		error_count = 0;
		items_sent = 0;
		stall_req = 1'b0;
		stall_left = 0;
		quiet_cycles = 0;
		src_idle_pct = 14;
		snk_idle_pct = 60;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_scale_extremes();
		program_regs(THR_SCALE_RST, AXIS_SCALE_RST, CTL_HOLD_RST);
		random_run(200);
		program_regs(SCALE_W'(300000), '1, HOLD_W'(0));
		random_run(200);

		settle_outputs();
		src_idle_pct = 60;
		snk_idle_pct = 14;
		program_regs('1, '0, '1);
		random_run(200);
		test_output_backpressure();
		program_regs(SCALE_W'($urandom), SCALE_W'($urandom), HOLD_W'($urandom_range(12)));
		random_run(200);

		settle_outputs();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		program_regs('0, SCALE_W'(120000), HOLD_W'(1));
		random_run(200);
		test_arming_sequence();
		program_regs(SCALE_W'(250000), SCALE_W'($urandom), HOLD_W'($urandom_range(6)));
		random_run(200);

		settle_outputs();
		repeat (10) @(posedge clk);
		if (error_count == 0 && predicted_results.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

// File: filelist.f
rtl/rcfs_pkg.sv
rtl/rc_failsafe_conditioner.sv
rtl/rcfs_checker.sv
tb/testbench.sv
